### design/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants for the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int SLICE_W   = TIME_W + 1;
    localparam int QUANT_W   = 8;
    localparam int LEVELS    = 4;
    localparam int LVL_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LEVEL0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LEVEL1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LEVEL2 = 2'd2;

    localparam logic [QUANT_W-1:0] QUANTUM_LEVEL0_RST = 8'd1;
    localparam logic [QUANT_W-1:0] QUANTUM_LEVEL1_RST = 8'd3;
    localparam logic [QUANT_W-1:0] QUANTUM_LEVEL2_RST = 8'd9;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam logic [LVL_W-1:0] LVL_TOP  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;
    localparam logic [LVL_W-1:0] LVL_FCFS = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   task_id;
        logic [TIME_W-1:0] run_time;
    } t_in_word;

    typedef struct packed {
        logic              running_valid;
        logic [ID_W-1:0]   running_id;
        logic [TIME_W-1:0] remaining;
        logic [LVL_W-1:0]  running_level;
        logic              dropped;
    } t_out_word;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] left;
    } t_entry;

endpackage

### design/multilevel_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Four-level feedback scheduler: three round-robin levels and one first-come
// level, one arrival or tick per word.
//
// channel   direction  handshake                   word
// in        input      i_in_valid / o_in_stall     mfs_pkg::t_in_word
// out       output     o_out_valid / i_out_stall   mfs_pkg::t_out_word
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one word per cycle unless stalled; the result shows the cycle after acceptance.
// the whole tick (retire, demote, priority pick, countdown) is combinational logic
// between the state registers and the output register.
// fifo heads sit in registers; a pop fetches the next entry at the same edge.
// reset is synchronous; fifos come out empty and quantum registers at 1, 3, 9.
// a stalled output holds the input back only while the output register is full.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  mfs_pkg::t_in_word                      i_in_word,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output mfs_pkg::t_out_word                     o_out_word,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mfs_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [mfs_pkg::QUANT_W-1:0]            i_cfg_data
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    mfs_pkg::t_entry r_mem [mfs_pkg::LEVELS][FIFO_DEPTH];

    logic [CNT_W-1:0] r_cnt  [mfs_pkg::LEVELS];
    logic [CNT_W-1:0] n_cnt  [mfs_pkg::LEVELS];
    logic [PTR_W-1:0] r_head [mfs_pkg::LEVELS];
    logic [PTR_W-1:0] r_tail [mfs_pkg::LEVELS];

    mfs_pkg::t_entry r_hq       [mfs_pkg::LEVELS];
    mfs_pkg::t_entry n_hq       [mfs_pkg::LEVELS];
    mfs_pkg::t_entry head_entry [mfs_pkg::LEVELS];
    mfs_pkg::t_entry r_rd;
    logic            r_rd_pend;
    logic [mfs_pkg::LVL_W-1:0] r_rd_lvl;

    logic [mfs_pkg::QUANT_W-1:0] r_quant [3];

    logic                          r_run_valid, n_run_valid;
    logic [mfs_pkg::ID_W-1:0]      r_run_task,  n_run_task;
    logic [mfs_pkg::TIME_W-1:0]    r_run_left,  n_run_left;
    logic [mfs_pkg::LVL_W-1:0]     r_run_level, n_run_level;
    logic [mfs_pkg::SLICE_W-1:0]   r_slice,     n_slice;

    logic                          r_out_valid;
    mfs_pkg::t_out_word            r_out, n_out;

    logic                          in_fire;
    logic                          push_en;
    logic [mfs_pkg::LVL_W-1:0]     push_lvl;
    mfs_pkg::t_entry               push_entry;
    logic                          pop_en;
    logic [mfs_pkg::LVL_W-1:0]     pop_lvl;
    mfs_pkg::t_entry               pop_entry;
    logic                          rd_en;
    logic [PTR_W-1:0]              rd_ptr;
    logic [mfs_pkg::LVL_W-1:0]     down_lvl;
    logic                          any_wait;
    logic                          dropped;

    function automatic logic [mfs_pkg::SLICE_W-1:0] lvl_slice(
        input logic [mfs_pkg::LVL_W-1:0]  lvl,
        input logic [mfs_pkg::TIME_W-1:0] left
    );
        logic [mfs_pkg::SLICE_W-1:0] s;
        case (lvl)
            mfs_pkg::LVL_TOP: s = mfs_pkg::SLICE_W'(r_quant[0]);
            mfs_pkg::LVL_MID: s = mfs_pkg::SLICE_W'(r_quant[1]);
            mfs_pkg::LVL_LOW: s = mfs_pkg::SLICE_W'(r_quant[2]);
            default:          s = mfs_pkg::SLICE_W'(left);
        endcase
        return s;
    endfunction

    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    // head entry of each level, a fresh fetch overrides the held copy
    always_comb begin
        for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
            if (r_rd_pend && r_rd_lvl == mfs_pkg::LVL_W'(l)) begin
                head_entry[l] = r_rd;
            end else begin
                head_entry[l] = r_hq[l];
            end
        end
    end

    always_comb begin
        n_run_valid = r_run_valid;
        n_run_task  = r_run_task;
        n_run_left  = r_run_left;
        n_run_level = r_run_level;
        n_slice     = r_slice;
        for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
            n_cnt[l] = r_cnt[l];
        end
        push_en    = 1'b0;
        push_lvl   = mfs_pkg::LVL_TOP;
        push_entry = '0;
        pop_en     = 1'b0;
        pop_lvl    = mfs_pkg::LVL_TOP;
        pop_entry  = '0;
        rd_en      = 1'b0;
        rd_ptr     = '0;
        down_lvl   = mfs_pkg::LVL_FCFS;
        dropped    = 1'b0;
        any_wait   = 1'b0;
        for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
            if (r_cnt[l] != '0) begin
                any_wait = 1'b1;
            end
        end

        if (in_fire) begin
            if (i_in_word.mode == mfs_pkg::MODE_ARRIVAL) begin
                if (r_cnt[0] == CNT_FULL) begin
                    dropped = 1'b1;
                end else begin
                    push_en    = 1'b1;
                    push_lvl   = mfs_pkg::LVL_TOP;
                    push_entry = '{id: i_in_word.task_id, left: i_in_word.run_time};
                    n_cnt[0]   = r_cnt[0] + 1'b1;
                end
            end else begin
                // retire finished task
                if (n_run_valid && n_run_left == '0) begin
                    n_run_valid = 1'b0;
                end
                // expired slice
                if (n_run_valid && n_slice == '0) begin
                    if (any_wait) begin
                        down_lvl = (r_run_level == mfs_pkg::LVL_FCFS) ? mfs_pkg::LVL_FCFS
                                                                       : r_run_level + 1'b1;
                        if (r_cnt[down_lvl] == CNT_FULL) begin
                            dropped = 1'b1;
                        end else begin
                            push_en         = 1'b1;
                            push_lvl        = down_lvl;
                            push_entry      = '{id: r_run_task, left: r_run_left};
                            n_cnt[down_lvl] = r_cnt[down_lvl] + 1'b1;
                        end
                        n_run_valid = 1'b0;
                    end else begin
                        n_slice = lvl_slice(r_run_level, r_run_left);
                    end
                end
                // priority pick
                if (!n_run_valid) begin
                    for (int l = mfs_pkg::LEVELS - 1; l >= 0; l--) begin
                        if (n_cnt[l] != '0) begin
                            pop_en  = 1'b1;
                            pop_lvl = mfs_pkg::LVL_W'(l);
                        end
                    end
                    if (pop_en) begin
                        if (push_en && push_lvl == pop_lvl && r_cnt[pop_lvl] == '0) begin
                            pop_entry = push_entry;
                        end else begin
                            pop_entry = head_entry[pop_lvl];
                        end
                        rd_en  = r_cnt[pop_lvl] > CNT_ONE;
                        rd_ptr = (r_head[pop_lvl] == PTR_LAST) ? '0 : r_head[pop_lvl] + 1'b1;
                        n_cnt[pop_lvl] = n_cnt[pop_lvl] - 1'b1;
                        n_run_valid    = 1'b1;
                        n_run_task     = pop_entry.id;
                        n_run_left     = pop_entry.left;
                        n_run_level    = pop_lvl;
                        n_slice        = lvl_slice(pop_lvl, pop_entry.left);
                    end
                end
                // countdown
                if (n_run_valid) begin
                    if (n_slice != '0) begin
                        n_slice = n_slice - 1'b1;
                    end
                    if (n_run_left != '0) begin
                        n_run_left = n_run_left - 1'b1;
                    end
                end
            end
        end

        // a push becomes the head when its level was empty or this word pops its only entry
        for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
            n_hq[l] = head_entry[l];
            if (push_en && push_lvl == mfs_pkg::LVL_W'(l) &&
                (r_cnt[l] == '0 ||
                 (pop_en && pop_lvl == mfs_pkg::LVL_W'(l) && r_cnt[l] == CNT_ONE))) begin
                n_hq[l] = push_entry;
            end
        end

        n_out = '0;
        if (n_run_valid) begin
            n_out.running_valid = 1'b1;
            n_out.running_id    = n_run_task;
            n_out.remaining     = n_run_left;
            n_out.running_level = n_run_level;
        end
        n_out.dropped = dropped;
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[push_lvl][r_tail[push_lvl]] <= push_entry;
        end
        if (rd_en) begin
            r_rd <= r_mem[pop_lvl][rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
                r_cnt[l]  <= '0;
                r_head[l] <= '0;
                r_tail[l] <= '0;
                r_hq[l]   <= '0;
            end
            r_rd_pend   <= 1'b0;
            r_rd_lvl    <= '0;
            r_run_valid <= 1'b0;
            r_run_task  <= '0;
            r_run_left  <= '0;
            r_run_level <= '0;
            r_slice     <= '0;
        end else if (in_fire) begin
            for (int l = 0; l < mfs_pkg::LEVELS; l++) begin
                r_cnt[l] <= n_cnt[l];
                r_hq[l]  <= n_hq[l];
                if (push_en && push_lvl == mfs_pkg::LVL_W'(l)) begin
                    r_tail[l] <= (r_tail[l] == PTR_LAST) ? '0 : r_tail[l] + 1'b1;
                end
                if (pop_en && pop_lvl == mfs_pkg::LVL_W'(l)) begin
                    r_head[l] <= (r_head[l] == PTR_LAST) ? '0 : r_head[l] + 1'b1;
                end
            end
            r_rd_pend   <= rd_en;
            r_rd_lvl    <= pop_lvl;
            r_run_valid <= n_run_valid;
            r_run_task  <= n_run_task;
            r_run_left  <= n_run_left;
            r_run_level <= n_run_level;
            r_slice     <= n_slice;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant[0] <= mfs_pkg::QUANTUM_LEVEL0_RST;
            r_quant[1] <= mfs_pkg::QUANTUM_LEVEL1_RST;
            r_quant[2] <= mfs_pkg::QUANTUM_LEVEL2_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mfs_pkg::CFG_QUANTUM_LEVEL0: r_quant[0] <= i_cfg_data;
                mfs_pkg::CFG_QUANTUM_LEVEL1: r_quant[1] <= i_cfg_data;
                mfs_pkg::CFG_QUANTUM_LEVEL2: r_quant[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### tb/tb_multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_scheduler
// Streams arrival and tick words into the scheduler and checks each result
// word against a cycle-free model of the four level queues. The random
// stimulus covers queue floods, demotion down to the first-come level, and
// several quantum settings including zero and the maximum. Both sides stall
// at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_multilevel_feedback_scheduler;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    class run_tracker;
        mfs_pkg::t_entry             fifo_q[mfs_pkg::LEVELS][QDEPTH];
        int                          fifo_count[mfs_pkg::LEVELS];
        int                          fifo_head[mfs_pkg::LEVELS];
        logic                        busy;
        logic [mfs_pkg::ID_W-1:0]    cur_id;
        logic [mfs_pkg::TIME_W-1:0]  cur_left;
        logic [mfs_pkg::LVL_W-1:0]   cur_level;
        logic [mfs_pkg::SLICE_W-1:0] slice;
        logic [mfs_pkg::QUANT_W-1:0] quantum[3];
        mfs_pkg::t_out_word          expected_runs[$];
        int                          mismatches;
        int                          strays;
        int                          results;
        int                          drops;
        int                          arrivals;
        int                          ticks;

        function new();
            int i;
            for (i = 0; i < mfs_pkg::LEVELS; i++) begin
                fifo_count[i] = 0;
                fifo_head[i]  = 0;
            end
            busy       = 1'b0;
            cur_id     = '0;
            cur_left   = '0;
            cur_level  = mfs_pkg::LVL_TOP;
            slice      = '0;
            quantum[0] = mfs_pkg::QUANTUM_LEVEL0_RST;
            quantum[1] = mfs_pkg::QUANTUM_LEVEL1_RST;
            quantum[2] = mfs_pkg::QUANTUM_LEVEL2_RST;
            mismatches = 0;
            strays     = 0;
            results    = 0;
            drops      = 0;
            arrivals   = 0;
            ticks      = 0;
        endfunction

        function void set_quantum(logic [mfs_pkg::CFG_IDX_W-1:0] idx,
                                  logic [mfs_pkg::QUANT_W-1:0] v);
            if (idx <= mfs_pkg::CFG_QUANTUM_LEVEL2) quantum[idx] = v;
        endfunction

        function logic [mfs_pkg::SLICE_W-1:0] fresh_slice(logic [mfs_pkg::LVL_W-1:0] lvl);
            if (lvl == mfs_pkg::LVL_FCFS) return {1'b0, cur_left};
            return mfs_pkg::SLICE_W'(quantum[lvl]);
        endfunction

        function bit enqueue(logic [mfs_pkg::LVL_W-1:0] lvl, logic [mfs_pkg::ID_W-1:0] id,
                             logic [mfs_pkg::TIME_W-1:0] left);
            int slot;
            if (fifo_count[lvl] >= QDEPTH) return 1'b0;
            slot = (fifo_head[lvl] + fifo_count[lvl]) % QDEPTH;
            fifo_q[lvl][slot].id   = id;
            fifo_q[lvl][slot].left = left;
            fifo_count[lvl]++;
            return 1'b1;
        endfunction

        function void note_word(mfs_pkg::t_in_word w);
            mfs_pkg::t_out_word        r;
            logic                      drop;
            logic                      waiting;
            logic [mfs_pkg::LVL_W-1:0] lower;
            mfs_pkg::t_entry           e;
            int                        lvl;
            drop = 1'b0;
            if (w.mode == mfs_pkg::MODE_ARRIVAL) begin
                arrivals++;
                if (!enqueue(mfs_pkg::LVL_TOP, w.task_id, w.run_time)) drop = 1'b1;
            end else begin
                ticks++;
                if (busy && cur_left == 0) busy = 1'b0;
                if (busy && slice == 0) begin
                    waiting = 1'b0;
                    for (lvl = 0; lvl < mfs_pkg::LEVELS; lvl++) begin
                        if (fifo_count[lvl] != 0) waiting = 1'b1;
                    end
                    if (waiting) begin
                        lower = (cur_level == mfs_pkg::LVL_FCFS) ? mfs_pkg::LVL_FCFS
                                                                 : mfs_pkg::LVL_W'(cur_level + 1);
                        if (!enqueue(lower, cur_id, cur_left)) drop = 1'b1;
                        busy = 1'b0;
                    end else begin
                        slice = fresh_slice(cur_level);
                    end
                end
                // highest non-empty level wins
                for (lvl = 0; lvl < mfs_pkg::LEVELS && !busy; lvl++) begin
                    if (fifo_count[lvl] != 0) begin
                        e = fifo_q[lvl][fifo_head[lvl]];
                        fifo_head[lvl] = (fifo_head[lvl] + 1) % QDEPTH;
                        fifo_count[lvl]--;
                        busy      = 1'b1;
                        cur_id    = e.id;
                        cur_left  = e.left;
                        cur_level = mfs_pkg::LVL_W'(lvl);
                        slice     = fresh_slice(cur_level);
                    end
                end
                if (busy) begin
                    if (slice != 0) slice = slice - 1'b1;
                    if (cur_left != 0) cur_left = cur_left - 1'b1;
                end
            end
            r = '0;
            if (busy) begin
                r.running_valid = 1'b1;
                r.running_id    = cur_id;
                r.remaining     = cur_left;
                r.running_level = cur_level;
            end
            r.dropped = drop;
            expected_runs.push_back(r);
        endfunction

        function void check_word(mfs_pkg::t_out_word got);
            mfs_pkg::t_out_word want;
            if (expected_runs.size() == 0) begin
                strays++;
                if (mismatches + strays <= 10)
                    $display("unexpected result word: valid %0b id %0d left %0d level %0d drop %0b",
                             got.running_valid, got.running_id, got.remaining,
                             got.running_level, got.dropped);
                return;
            end
            want = expected_runs.pop_front();
            results++;
            if (want.dropped) drops++;
            if (got.running_valid !== want.running_valid || got.running_id !== want.running_id ||
                got.remaining !== want.remaining || got.running_level !== want.running_level ||
                got.dropped !== want.dropped) begin
                mismatches++;
                if (mismatches + strays <= 10) begin
                    $display("mismatch at result %0d: expected valid %0b id %0d left %0d",
                             results, want.running_valid, want.running_id, want.remaining);
                    $display("  level %0d drop %0b, got valid %0b id %0d left %0d level %0d drop %0b",
                             want.running_level, want.dropped, got.running_valid,
                             got.running_id, got.remaining, got.running_level, got.dropped);
                end
            end
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction

        function int failures();
            return mismatches + strays + expected_runs.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    mfs_pkg::t_in_word             in_word = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    mfs_pkg::t_out_word            out_word;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [mfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mfs_pkg::QUANT_W-1:0]   cfg_data = '0;
    logic                          quiet = 1'b0;
    int                            hold_reqs = 0;
    int                            cycles = 0;
    int                            sent = 0;
    int                            settings = 0;
    run_tracker                    tracker;

    initial forever #5 clk = ~clk;

    multilevel_feedback_scheduler #(
        .FIFO_DEPTH (QDEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) tracker.check_word(out_word);
            if (in_valid && !in_stall) tracker.note_word(in_word);
            if (cfg_valid && cfg_ready) tracker.set_quantum(cfg_index, cfg_data);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_multilevel_feedback_scheduler NOT OK");
            $finish;
        end
    end

    // output stall pattern, with an occasional long hold-off on request
    initial begin
        int served;
        int n;
        int r;
        served = 0;
        @(posedge clk);
        forever begin
            r = $urandom_range(0, 99);
            if (served != hold_reqs) begin
                served++;
                out_stall <= 1'b1;
                n = HOLD_CYCLES;
            end else if (quiet || r < 60) begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 8);
            end else if (r < 95) begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 3);
            end else begin
                out_stall <= 1'b1;
                n = $urandom_range(10, 40);
            end
            repeat (n) @(posedge clk);
        end
    end

    function int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function logic [mfs_pkg::TIME_W-1:0] pick_run_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 88) return mfs_pkg::TIME_W'($urandom_range(1, 12));
        return mfs_pkg::TIME_W'($urandom_range(13, 300));
    endfunction

    task automatic send_word(mfs_pkg::t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic send_arrival(logic [mfs_pkg::ID_W-1:0] id, logic [mfs_pkg::TIME_W-1:0] t);
        mfs_pkg::t_in_word w;
        w.mode     = mfs_pkg::MODE_ARRIVAL;
        w.task_id  = id;
        w.run_time = t;
        send_word(w);
    endtask

    // id and time fields carry noise on a tick
    task automatic send_tick();
        mfs_pkg::t_in_word w;
        w.mode     = mfs_pkg::MODE_TICK;
        w.task_id  = mfs_pkg::ID_W'($urandom);
        w.run_time = mfs_pkg::TIME_W'($urandom);
        send_word(w);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (tracker.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_quanta(logic [mfs_pkg::QUANT_W-1:0] q0, logic [mfs_pkg::QUANT_W-1:0] q1,
                              logic [mfs_pkg::QUANT_W-1:0] q2);
        logic [mfs_pkg::QUANT_W-1:0]   v[3];
        logic [mfs_pkg::CFG_IDX_W-1:0] idx[3];
        int                            i;
        v[0]   = q0;
        v[1]   = q1;
        v[2]   = q2;
        idx[0] = mfs_pkg::CFG_QUANTUM_LEVEL0;
        idx[1] = mfs_pkg::CFG_QUANTUM_LEVEL1;
        idx[2] = mfs_pkg::CFG_QUANTUM_LEVEL2;
        for (i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= v[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(int words);
        int start;
        int kind;
        int n;
        int i;
        int p;
        start = sent;
        while (sent - start < words) begin
            quiet <= ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                n = $urandom_range(4, 20);
                p = $urandom_range(20, 60);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 99) < p)
                        send_arrival(mfs_pkg::ID_W'($urandom), pick_run_time());
                    else
                        send_tick();
                end
            end else if (kind < 7) begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++) send_arrival(mfs_pkg::ID_W'($urandom), pick_run_time());
                n = $urandom_range(5, 40);
                for (i = 0; i < n; i++) send_tick();
            end else if (kind == 7) begin
                // fill the top queue so the long arrivals bounce, then push demotions
                repeat (2) begin
                    for (i = 0; i < QDEPTH; i++)
                        send_arrival(mfs_pkg::ID_W'($urandom),
                                     mfs_pkg::TIME_W'($urandom_range(2, 30)));
                    send_arrival(mfs_pkg::ID_W'($urandom), '1);
                    send_arrival(mfs_pkg::ID_W'($urandom), mfs_pkg::TIME_W'($urandom) | 16'h8000);
                    n = $urandom_range(20, 40);
                    for (i = 0; i < n; i++) send_tick();
                end
            end else begin
                n = $urandom_range(10, 60);
                for (i = 0; i < n; i++) send_tick();
            end
        end
    endtask

    initial begin
        int ph;
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick, zero and one run time, tasks long enough to sink to the bottom
        send_tick();
        send_arrival(8'h00, 16'd0);
        send_arrival(8'hFF, 16'd1);
        send_arrival(8'h5A, 16'd20);
        send_arrival(8'hA5, 16'd14);
        repeat (16) send_tick();
        settle();

        run_phase(145);
        settle();
        for (ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: begin
                    set_quanta(8'd0, 8'd0, 8'd0);
                    hold_reqs <= hold_reqs + 1;
                end
                2: set_quanta(8'd255, 8'd255, 8'd255);
                3: set_quanta(8'd1, 8'd1, 8'd1);
                4: set_quanta(8'd2, 8'd7, 8'd200);
                default: begin
                    set_quanta(mfs_pkg::QUANT_W'($urandom_range(1, 255)),
                               mfs_pkg::QUANT_W'($urandom_range(1, 255)),
                               mfs_pkg::QUANT_W'($urandom_range(1, 255)));
                end
            endcase
            run_phase(145);
            settle();
        end
        repeat (10) @(posedge clk);

        $display("run covered %0d arrivals and %0d ticks under %0d quantum settings",
                 tracker.arrivals, tracker.ticks, settings + 1);
        $display("%0d result words checked, %0d with a drop, %0d mismatches, %0d unexpected",
                 tracker.results, tracker.drops, tracker.mismatches, tracker.strays);
        if (tracker.failures() == 0) begin
            $display("tb_multilevel_feedback_scheduler OK");
        end else begin
            $display("tb_multilevel_feedback_scheduler NOT OK");
        end
        $finish;
    end

endmodule
